// ===== hw/rtl/olis_pkg.sv =====
// shared constants, codes and control structs for the ordered list block
package olis_pkg;

    localparam int DEPTH_DEF = 32;

    localparam int OP_W  = 3;
    localparam int VAL_W = 32;
    localparam int POS_W = 6;
    localparam int ST_W  = 2;
    // compare width for positions and lengths, holds DEPTH+1 at the largest depth
    localparam int CMP_W = 8;

    localparam logic [OP_W-1:0] OP_INS_HEAD   = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_TAIL   = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_POS    = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND_FIRST = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND_ALL   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;

    typedef struct packed {
        logic load;
        logic exec;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic op_valid;
        logic last;
    } t_sts;

endpackage

// ===== hw/rtl/olis_dp.sv =====
// datapath: list cells, length, match vector and result register
module olis_dp
    import olis_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic [OP_W-1:0]  i_op,
    input  logic [VAL_W-1:0] i_item_value,
    input  logic [POS_W-1:0] i_target_position,
    output logic [ST_W-1:0]  o_status,
    output logic             o_found,
    output logic [POS_W-1:0] o_match_position,
    output logic             o_last_result,
    output logic [POS_W-1:0] o_list_length
);

    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    logic [OP_W-1:0]  r_op;
    logic [VAL_W-1:0] r_value;
    logic [POS_W-1:0] r_tpos;
    logic [VAL_W-1:0] r_cells [DEPTH];
    logic [VAL_W-1:0] n_cells [DEPTH];
    logic [LEN_W-1:0] r_length;
    logic [DEPTH-1:0] r_match;
    logic [DEPTH-1:0] n_match;
    logic [ST_W-1:0]  r_status;

    logic [ST_W-1:0]  r_out_status;
    logic             r_out_found;
    logic [POS_W-1:0] r_out_pos;
    logic             r_out_last;
    logic [POS_W-1:0] r_out_len;

    logic             w_is_insert;
    logic [CMP_W-1:0] w_len;
    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_ins_idx;
    logic             w_full;
    logic             w_bad;
    logic [ST_W-1:0]  w_ins_st;

    logic [DEPTH-1:0] w_low;
    logic [DEPTH-1:0] w_rest;
    logic [IDX_W-1:0] w_idx;
    logic             w_any;
    logic [POS_W-1:0] w_mpos;
    logic             w_last;

    assign w_is_insert = r_op inside {OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS};
    assign w_len       = CMP_W'(r_length);

    always_comb begin
        case (r_op)
            OP_INS_HEAD: w_pos = CMP_W'(1);
            OP_INS_TAIL: w_pos = w_len + CMP_W'(1);
            default:     w_pos = CMP_W'(r_tpos);
        endcase
    end

    // full takes priority over a bad position
    assign w_full    = (r_length == LEN_W'(DEPTH));
    assign w_bad     = (w_pos == '0) || (w_pos > w_len + CMP_W'(1));
    assign w_ins_st  = w_full ? ST_FULL : (w_bad ? ST_BADPOS : ST_OK);
    assign w_ins_idx = w_pos - CMP_W'(1);

    // each cell keeps or takes the new value; every cell but the head can also take its front neighbor
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            always_comb begin
                if (w_ins_idx == '0) begin
                    n_cells[g] = r_value;
                end else begin
                    n_cells[g] = r_cells[g];
                end
            end
        end else begin : g_body
            always_comb begin
                if (CMP_W'(g) < w_ins_idx) begin
                    n_cells[g] = r_cells[g];
                end else if (CMP_W'(g) == w_ins_idx) begin
                    n_cells[g] = r_value;
                end else begin
                    n_cells[g] = r_cells[g-1];
                end
            end
        end
        assign n_match[g] = (CMP_W'(g) < w_len) && (r_cells[g] == r_value);
    end

    // lowest pending match, one-hot, then encoded
    assign w_low  = r_match & (~r_match + DEPTH'(1));
    assign w_rest = r_match & ~w_low;
    assign w_any  = |r_match;

    always_comb begin
        w_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_low[i]) begin
                w_idx = w_idx | IDX_W'(i);
            end
        end
    end

    assign w_mpos = POS_W'(LEN_W'(w_idx) + LEN_W'(1));
    assign w_last = w_is_insert || (r_op == OP_FIND_FIRST) || !w_any || (w_rest == '0);

    assign o_sts.op_valid = (r_op <= OP_FIND_ALL);
    assign o_sts.last     = w_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_value <= i_item_value;
            r_tpos  <= i_target_position;
        end
        if (i_cmd.exec && w_is_insert) begin
            r_status <= w_ins_st;
            if (w_ins_st == ST_OK) begin
                r_cells <= n_cells;
            end
        end
        if (i_cmd.exec && !w_is_insert) begin
            r_match <= n_match;
        end else if (i_cmd.emit) begin
            r_match <= w_rest;
        end
        if (i_cmd.emit) begin
            r_out_len <= POS_W'(r_length);
            if (w_is_insert) begin
                r_out_status <= r_status;
                r_out_found  <= 1'b0;
                r_out_pos    <= '0;
                r_out_last   <= 1'b1;
            end else begin
                r_out_status <= ST_OK;
                r_out_found  <= w_any;
                r_out_pos    <= w_any ? w_mpos : '0;
                r_out_last   <= w_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= '0;
        end else if (i_cmd.exec && w_is_insert && (w_ins_st == ST_OK)) begin
            r_length <= r_length + LEN_W'(1);
        end
    end

    assign o_status         = r_out_status;
    assign o_found          = r_out_found;
    assign o_match_position = r_out_pos;
    assign o_last_result    = r_out_last;
    assign o_list_length    = r_out_len;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_length <= LEN_W'(DEPTH))
        else $error("list length above depth");

endmodule

// ===== hw/rtl/olis_ctrl.sv =====
// controller: request sequencing and result handshake
module olis_ctrl
    import olis_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_fire;
    logic   w_take;
    logic   w_accept;

    // result loads when the output register is empty or being drained
    assign w_fire   = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);
    assign w_take   = (r_state == S_IDLE) || (w_fire && i_sts.last);
    assign w_accept = i_in_valid && w_take;

    assign o_in_stall  = !w_take;
    assign o_out_valid = r_out_valid;

    assign o_cmd.load = w_accept;
    assign o_cmd.exec = (r_state == S_EXEC);
    assign o_cmd.emit = w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    // unused ops give no result
                    r_state <= i_sts.op_valid ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (w_fire && i_sts.last) begin
                        r_state <= w_accept ? S_EXEC : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_exec_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state == S_EMIT) || (r_state == S_IDLE))
        else $error("execute not followed by emit or idle");

    a_last_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_sts.last) |=> (r_state != S_EMIT))
        else $error("emit continues after last result");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> o_in_stall)
        else $error("request taken during execute");

endmodule

// ===== hw/rtl/ordered_list_insert_search.sv =====
// top level: ordered list with insert and search
//
//  channel   direction  handshake                   payload
//  request   in         i_in_valid / o_in_stall     i_op, i_item_value, i_target_position
//  result    out        o_out_valid / i_out_stall   o_status, o_found, o_match_position,
//                                                   o_last_result, o_list_length
//
// inserts and first-match searches run an execute state on the cell row, then an emit
// state that loads the result register once it is free (next request taken then)
// all-match searches give N results (at least one), one per match, from the emit state
// unused ops pass through the execute state and give no result
// reset empties the list; cell contents are not cleared
// a stalled result holds in the output register; the next result waits for it
module ordered_list_insert_search
    import olis_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [OP_W-1:0]  i_op,
    input  logic [VAL_W-1:0] i_item_value,
    input  logic [POS_W-1:0] i_target_position,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [ST_W-1:0]  o_status,
    output logic             o_found,
    output logic [POS_W-1:0] o_match_position,
    output logic             o_last_result,
    output logic [POS_W-1:0] o_list_length
);

    t_cmd w_cmd;
    t_sts w_sts;

    olis_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    olis_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_op              (i_op),
        .i_item_value      (i_item_value),
        .i_target_position (i_target_position),
        .o_status          (o_status),
        .o_found           (o_found),
        .o_match_position  (o_match_position),
        .o_last_result     (o_last_result),
        .o_list_length     (o_list_length)
    );

endmodule

// ===== dv/ordered_list_insert_search_tb.sv =====
// testbench for the ordered list block: random requests with stalls, checked against a list model
`timescale 1ns / 100ps

module ordered_list_insert_search_tb;
    import olis_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] tpos;
    } t_list_req;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic             found;
        logic [POS_W-1:0] match_pos;
        logic             last;
        logic [POS_W-1:0] len;
    } t_list_resp;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic [OP_W-1:0]  i_op = '0;
    logic [VAL_W-1:0] i_item_value = '0;
    logic [POS_W-1:0] i_target_position = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [ST_W-1:0]  o_status;
    logic             o_found;
    logic [POS_W-1:0] o_match_position;
    logic             o_last_result;
    logic [POS_W-1:0] o_list_length;

    // request stream and list model
    t_list_req        pending_reqs[$];
    t_list_resp       expected_resps[$];
    logic [VAL_W-1:0] list_vals[LIST_DEPTH];
    int               list_len = 0;
    int               gen_len = 0;

    logic req_taken = 1'b0;
    logic resp_taken = 1'b0;
    logic hold_off = 1'b0;
    int   send_wait = 0;
    int   recv_wait = 0;
    bit   send_quiet = 1'b0;
    bit   recv_quiet = 1'b0;
    int   reqs_accepted = 0;
    int   err_count = 0;

    ordered_list_insert_search #(
        .DEPTH(LIST_DEPTH)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_op              (i_op),
        .i_item_value      (i_item_value),
        .i_target_position (i_target_position),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_found           (o_found),
        .o_match_position  (o_match_position),
        .o_last_result     (o_last_result),
        .o_list_length     (o_list_length)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // queue a request, tracking the list length it will leave behind
    function automatic void queue_req(logic [OP_W-1:0] op, logic [VAL_W-1:0] value,
                                      logic [POS_W-1:0] tpos);
        int p;
        p = (op == OP_INS_HEAD) ? 1 : (op == OP_INS_TAIL) ? gen_len + 1 : int'(tpos);
        if ((op == OP_INS_HEAD || op == OP_INS_TAIL || op == OP_INS_POS) &&
            gen_len < LIST_DEPTH && p >= 1 && p <= gen_len + 1)
            gen_len++;
        pending_reqs.push_back('{op: op, value: value, tpos: tpos});
    endfunction

    // few distinct values so that searches hit several entries
    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] common_vals[5];
        common_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0000_002A};
        if ($urandom_range(0, 1) == 0)
            return common_vals[$urandom_range(0, 4)];
        return $urandom;
    endfunction

    function automatic void push_resp(logic [ST_W-1:0] status, logic found, int pos,
                                      logic last);
        expected_resps.push_back('{status: status, found: found, match_pos: pos[POS_W-1:0],
                                   last: last, len: list_len[POS_W-1:0]});
    endfunction

    function automatic void predict_list_op(t_list_req req);
        int p;
        int hits;
        int seen;
        logic [ST_W-1:0] st;
        case (req.op)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
                p = (req.op == OP_INS_HEAD) ? 1 :
                    (req.op == OP_INS_TAIL) ? list_len + 1 : int'(req.tpos);
                // full is reported ahead of a bad position
                if (list_len >= LIST_DEPTH) begin
                    st = ST_FULL;
                end else if (p == 0 || p > list_len + 1) begin
                    st = ST_BADPOS;
                end else begin
                    for (int i = list_len; i >= p; i--)
                        list_vals[i] = list_vals[i-1];
                    list_vals[p-1] = req.value;
                    list_len++;
                    st = ST_OK;
                end
                push_resp(st, 1'b0, 0, 1'b1);
            end
            OP_FIND_FIRST: begin
                p = 0;
                for (int i = 0; i < list_len; i++) begin
                    if (p == 0 && list_vals[i] == req.value)
                        p = i + 1;
                end
                push_resp(ST_OK, p != 0, p, 1'b1);
            end
            OP_FIND_ALL: begin
                hits = 0;
                seen = 0;
                for (int i = 0; i < list_len; i++) begin
                    if (list_vals[i] == req.value)
                        hits++;
                end
                if (hits == 0)
                    push_resp(ST_OK, 1'b0, 0, 1'b1);
                for (int i = 0; i < list_len; i++) begin
                    if (list_vals[i] == req.value) begin
                        seen++;
                        push_resp(ST_OK, 1'b1, i + 1, seen == hits);
                    end
                end
            end
            default: begin
                // unused ops leave no trace
            end
        endcase
    endfunction

    function automatic void check_resp(t_list_resp got);
        t_list_resp want;
        if (expected_resps.size() == 0) begin
            err_count++;
            if (err_count <= 10)
                $display("unexpected result: st=%0d found=%0d pos=%0d last=%0d len=%0d",
                         got.status, got.found, got.match_pos, got.last, got.len);
            return;
        end
        want = expected_resps.pop_front();
        if (got.status !== want.status || got.found !== want.found ||
            got.match_pos !== want.match_pos || got.last !== want.last ||
            got.len !== want.len) begin
            err_count++;
            if (err_count <= 10) begin
                $write("mismatch at %0t: want st=%0d found=%0d pos=%0d last=%0d len=%0d, ",
                       $realtime, want.status, want.found, want.match_pos, want.last,
                       want.len);
                $display("got st=%0d found=%0d pos=%0d last=%0d len=%0d",
                         got.status, got.found, got.match_pos, got.last, got.len);
            end
        end
    endfunction

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
            resp_taken <= 1'b0;
        end else begin
            req_taken <= i_in_valid && !o_in_stall;
            resp_taken <= o_out_valid && !i_out_stall;
            if (i_in_valid && !o_in_stall) begin
                reqs_accepted++;
                predict_list_op('{op: i_op, value: i_item_value, tpos: i_target_position});
            end
            if (o_out_valid && !i_out_stall)
                check_resp('{status: o_status, found: o_found, match_pos: o_match_position,
                             last: o_last_result, len: o_list_length});
        end
    end

    // request driver
    always @(negedge i_clk) begin
        t_list_req nxt;
        if (i_rst_n && !(i_in_valid && !req_taken)) begin
            if (i_in_valid) begin
                if ($urandom_range(0, 15) == 0)
                    send_quiet = !send_quiet;
                send_wait = send_quiet ? 0 : $urandom_range(0, 19);
            end
            if (send_wait == 0 && pending_reqs.size() != 0) begin
                nxt = pending_reqs.pop_front();
                i_in_valid <= 1'b1;
                i_op <= nxt.op;
                i_item_value <= nxt.value;
                i_target_position <= nxt.tpos;
            end else begin
                i_in_valid <= 1'b0;
                if (send_wait != 0)
                    send_wait--;
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (resp_taken) begin
            if ($urandom_range(0, 15) == 0)
                recv_quiet = !recv_quiet;
            recv_wait = recv_quiet ? 0 : $urandom_range(0, 19);
        end else if (recv_wait != 0 && o_out_valid) begin
            recv_wait--;
        end
        i_out_stall <= hold_off || (recv_wait != 0);
    end

    // one long hold-off on the result side so the block backs up
    initial begin
        while (reqs_accepted < 60)
            @(posedge i_clk);
        @(negedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(negedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int counted;
        int roll;
        logic [OP_W-1:0] op;
        logic [POS_W-1:0] tpos;

        // empty list, bad positions, extremes, duplicates, unused ops
        queue_req(OP_FIND_FIRST, 32'h0, 6'd0);
        queue_req(OP_FIND_ALL, 32'h0, 6'd0);
        queue_req(OP_INS_POS, 32'h5, 6'd0);
        queue_req(OP_INS_POS, 32'h5, 6'd2);
        queue_req(OP_INS_POS, 32'h5, 6'h3F);
        queue_req(OP_INS_POS, 32'h8000_0000, 6'd1);
        queue_req(OP_INS_TAIL, 32'h7FFF_FFFF, 6'd0);
        queue_req(OP_INS_HEAD, 32'hFFFF_FFFF, 6'h3F);
        queue_req(OP_INS_POS, 32'h0, 6'd4);
        queue_req(OP_INS_POS, 32'h5555_5555, 6'd2);
        queue_req(OP_INS_TAIL, 32'h8000_0000, 6'd0);
        queue_req(OP_INS_HEAD, 32'h8000_0000, 6'd0);
        queue_req(OP_FIND_FIRST, 32'h8000_0000, 6'd0);
        queue_req(OP_FIND_ALL, 32'h8000_0000, 6'h3F);
        queue_req(OP_FIND_FIRST, 32'h7FFF_FFFF, 6'd0);
        queue_req(OP_FIND_FIRST, 32'h1234_5678, 6'd0);
        queue_req(OP_FIND_ALL, 32'h1234_5678, 6'd0);
        queue_req(OP_FIND_ALL, 32'hFFFF_FFFF, 6'd0);
        queue_req(3'd5, 32'hAAAA_AAAA, 6'd1);
        queue_req(3'd6, 32'h5555_5555, 6'h2A);
        queue_req(3'd7, 32'hFFFF_FFFF, 6'h3F);
        queue_req(OP_FIND_FIRST, 32'hAAAA_AAAA, 6'h2A);

        counted = 0;
        while (counted < 130) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                queue_req(OP_W'($urandom_range(5, 7)), $urandom, POS_W'($urandom_range(0, 63)));
            end else if (roll < ((gen_len < LIST_DEPTH) ? 55 : 25)) begin
                op = OP_W'($urandom_range(0, 2));
                tpos = POS_W'($urandom_range(0, 63));
                if (op == OP_INS_POS && $urandom_range(0, 4) != 0)
                    tpos = POS_W'($urandom_range(1, gen_len + 1));
                queue_req(op, pick_value(), tpos);
                counted++;
            end else begin
                op = ($urandom_range(0, 1) == 0) ? OP_FIND_FIRST : OP_FIND_ALL;
                queue_req(op, pick_value(), POS_W'($urandom_range(0, 63)));
                counted++;
            end
        end

        // make sure the list ends up full, then hit it with every insert form
        while (gen_len < LIST_DEPTH)
            queue_req(OP_INS_TAIL, 32'h0F0F_0F0F, POS_W'($urandom_range(0, 63)));
        queue_req(OP_INS_POS, 32'h1, 6'd0);
        queue_req(OP_INS_POS, 32'h1, 6'h3F);
        queue_req(OP_INS_POS, 32'h1, 6'd5);
        queue_req(OP_INS_HEAD, 32'h1, 6'd0);
        queue_req(OP_INS_TAIL, 32'h1, 6'd0);
        queue_req(OP_FIND_ALL, 32'h0F0F_0F0F, 6'd0);
        queue_req(OP_FIND_ALL, 32'h8000_0000, 6'd0);

        while (!i_rst_n)
            @(posedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (expected_resps.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
